// ===== design/motg_pkg.sv =====
// Package for the motor overcurrent trip guard.
// Holds item structs, command kinds, action and register codes, fixed widths.
// No dependencies.
package motg_pkg;

  // Fixed field widths
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned LIMIT_W    = 12;
  localparam int unsigned TRIP_W     = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 12'd662;
  localparam logic [TRIP_W-1:0]  TRIP_RST     = 8'd20;
  localparam logic [TIME_W-1:0]  INTERVAL_RST = 32'd21600000;
  localparam logic [TIME_W-1:0]  IDLE_RST     = 32'd60000;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TRIP     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_IDLE     = 2'd3;

  // Input action codes
  localparam logic [1:0] ACTION_GUARD = 2'd0;
  localparam logic [1:0] ACTION_CAL   = 2'd1;
  localparam logic [1:0] ACTION_TICK  = 2'd2;

  // Trip action codes
  localparam logic [2:0] ACT_NONE          = 3'd0;
  localparam logic [2:0] ACT_RESYNC_CLOSED = 3'd1;
  localparam logic [2:0] ACT_REVERSE       = 3'd2;
  localparam logic [2:0] ACT_RESYNC_OPEN   = 3'd3;
  localparam logic [2:0] ACT_STOP_OPENING  = 3'd4;

  localparam logic [TRIP_W-1:0] RUN_MAX = 8'd255;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_GUARD,
    KIND_CAL,
    KIND_TICK
  } kind_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADC_W-1:0]  adc_sample;
    logic              slow_mode;
    logic              closing;
    logic              near_closed;
    logic              near_open;
    logic              door_stopped;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              window_done;
    logic              tripped;
    logic [2:0]        trip_action;
    logic [TRIP_W-1:0] over_windows;
    logic              zero_updated;
    logic              recal_due;
  } out_item_t;

  // Classified command from front to back
  typedef struct packed {
    kind_e             kind;
    logic              slow;
    logic              closing;
    logic              near_closed;
    logic              near_open;
    logic              door_stopped;
    logic [TIME_W-1:0] now;
  } cmd_t;

endpackage

// ===== design/motg_fifo.sv =====
// Small register queue with full/empty flags.
// Used for the command queue and the result queue; no package dependency.
module motg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("queue empty after lone push");

  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push && count_q == CNT_W'(1)) |=> empty_o)
    else $error("queue not empty after popping last item");
`endif

endmodule

// ===== design/motg_front.sv =====
// Front end: accepts input items, classifies them and prescales samples.
// Depends on motg_pkg and motg_fifo (command queue toward the back end).
module motg_front #(
  parameter int unsigned GUARD_SAMPLES = 32,
  parameter int unsigned CAL_SAMPLES   = 200,
  parameter int unsigned ADC_BITS      = 12,
  parameter int unsigned SC_W          = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  motg_pkg::in_item_t in_item_i,
  output logic              full,
  output logic              cmd_valid_o,
  output motg_pkg::cmd_t    cmd_o,
  output logic [SC_W-1:0]   scaled_o,
  input  logic              cmd_pop_i
);
  import motg_pkg::*;

  localparam int unsigned SAMP_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam int unsigned Q_W    = $bits(cmd_t) + SC_W;

  cmd_t             cmd_d;
  logic [SC_W-1:0]  scaled_d;
  logic [SAMP_W-1:0] sample;
  logic [Q_W-1:0]   q_in, q_out;
  logic             q_empty;

  assign sample = in_item_i.adc_sample[SAMP_W-1:0];

  // Classify the item
  always_comb begin
    cmd_d.slow         = in_item_i.slow_mode;
    cmd_d.closing      = in_item_i.closing;
    cmd_d.near_closed  = in_item_i.near_closed;
    cmd_d.near_open    = in_item_i.near_open;
    cmd_d.door_stopped = in_item_i.door_stopped;
    cmd_d.now          = in_item_i.now_ms;
    unique case (in_item_i.action)
      ACTION_GUARD: cmd_d.kind = KIND_GUARD;
      ACTION_CAL:   cmd_d.kind = KIND_CAL;
      ACTION_TICK:  cmd_d.kind = KIND_TICK;
      default:      cmd_d.kind = KIND_NONE;
    endcase
  end

  // Prescale: guard samples by the calibration length, all other items by the window length
  always_comb begin
    if (cmd_d.kind == KIND_GUARD) begin
      scaled_d = SC_W'(sample) * SC_W'(CAL_SAMPLES);
    end else begin
      scaled_d = SC_W'(sample) * SC_W'(GUARD_SAMPLES);
    end
  end

  assign q_in = {cmd_d, scaled_d};

  motg_fifo #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign {cmd_o, scaled_o} = q_out;
  assign cmd_valid_o       = !q_empty;

endmodule

// ===== design/motg_back.sv =====
// Back end: configuration registers, accumulators, window compare and trip count.
// Depends on motg_pkg and motg_fifo (result queue).
module motg_back #(
  parameter int unsigned GUARD_SAMPLES = 32,
  parameter int unsigned CAL_SAMPLES   = 200,
  parameter int unsigned ADC_BITS      = 12,
  parameter int unsigned SC_W          = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [motg_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [motg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                cmd_valid_i,
  input  motg_pkg::cmd_t                      cmd_i,
  input  logic [SC_W-1:0]                     scaled_i,
  output logic                                cmd_pop_o,
  input  logic                                pop,
  output logic                                empty,
  output motg_pkg::out_item_t                 out_item_o
);
  import motg_pkg::*;

  localparam int unsigned SAMP_W  = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam int unsigned CG      = $clog2(GUARD_SAMPLES);
  localparam int unsigned CC      = $clog2(CAL_SAMPLES);
  localparam int unsigned ACC_W   = SAMP_W + CG + CC;
  localparam int unsigned LIM_W   = LIMIT_W + CG + CC;
  localparam int unsigned CMP_W   = ((ACC_W > LIM_W) ? ACC_W : LIM_W) + 3;
  localparam int unsigned FILL_W  = $clog2(GUARD_SAMPLES + 1);
  localparam int unsigned CFILL_W = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned WIN_K   = GUARD_SAMPLES * CAL_SAMPLES;
  localparam int unsigned BASE_RST = 662 * WIN_K;

  // Configuration registers and prescaled limits
  logic [LIMIT_W-1:0] limit_q;
  logic [TRIP_W-1:0]  trip_q;
  logic [TIME_W-1:0]  interval_q, idle_q;
  logic [LIM_W-1:0]   base_q;
  logic [LIM_W+1:0]   base4_q;

  // Block state
  logic [ACC_W-1:0]   guard_acc_q, guard_acc_d;
  logic [FILL_W-1:0]  guard_fill_q, guard_fill_d;
  logic [ACC_W-1:0]   cal_acc_q, cal_acc_d;
  logic [CFILL_W-1:0] cal_fill_q, cal_fill_d;
  logic [ACC_W-1:0]   zero_q, zero_d;
  logic [TRIP_W-1:0]  over_run_q;
  logic               was_stopped_q, was_stopped_d;
  logic [TIME_W-1:0]  since_q, since_d, last_recal_q, last_recal_d;

  // Compare stage
  logic               s1_valid_q;
  logic               s1_win_q, s1_slow_q, s1_closing_q, s1_nc_q, s1_no_q;
  logic               s1_zupd_q, s1_recal_q;
  logic [ACC_W-1:0]   s1_acc_q, s1_zero_q;
  logic               s1_win_d, s1_zupd_d, s1_recal_d;

  logic               advance, res_push, res_full;
  logic               guard_hit, cal_hit, tick_hit;
  logic [ACC_W-1:0]   g_sum, c_sum;
  logic               g_last, c_last;
  logic [TIME_W-1:0]  since_eff, since_gap, recal_gap;

  logic [ACC_W-1:0]   diff;
  logic [CMP_W-1:0]   lhs, rhs;
  logic               over, trip;
  logic [TRIP_W-1:0]  cnt, run_next;
  out_item_t          res_d;

  // Write configuration and refresh the scaled limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LIMIT_RST;
      trip_q     <= TRIP_RST;
      interval_q <= INTERVAL_RST;
      idle_q     <= IDLE_RST;
      base_q     <= LIM_W'(BASE_RST);
      base4_q    <= (LIM_W + 2)'(BASE_RST) << 2;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LIMIT:    limit_q    <= cfg_wdata_i[LIMIT_W-1:0];
          REG_TRIP:     trip_q     <= cfg_wdata_i[TRIP_W-1:0];
          REG_INTERVAL: interval_q <= cfg_wdata_i[TIME_W-1:0];
          REG_IDLE:     idle_q     <= cfg_wdata_i[TIME_W-1:0];
          default:      ;
        endcase
      end
      base_q  <= LIM_W'(limit_q) * LIM_W'(WIN_K);
      base4_q <= {base_q, 2'b00};
    end
  end

  // Handshake between command queue, compare stage and result queue
  assign advance   = !s1_valid_q || !res_full;
  assign cmd_pop_o = cmd_valid_i && advance;
  assign res_push  = s1_valid_q && !res_full;

  assign guard_hit = cmd_pop_o && (cmd_i.kind == KIND_GUARD);
  assign cal_hit   = cmd_pop_o && (cmd_i.kind == KIND_CAL);
  assign tick_hit  = cmd_pop_o && (cmd_i.kind == KIND_TICK);

  assign g_sum  = guard_acc_q + ACC_W'(scaled_i);
  assign c_sum  = cal_acc_q + ACC_W'(scaled_i);
  assign g_last = (guard_fill_q == FILL_W'(GUARD_SAMPLES - 1));
  assign c_last = (cal_fill_q == CFILL_W'(CAL_SAMPLES - 1));

  assign since_eff = was_stopped_q ? since_q : cmd_i.now;
  assign since_gap = cmd_i.now - since_eff;
  assign recal_gap = cmd_i.now - last_recal_q;

  // Accumulate samples and track the stopped interval
  always_comb begin
    guard_acc_d   = guard_acc_q;
    guard_fill_d  = guard_fill_q;
    cal_acc_d     = cal_acc_q;
    cal_fill_d    = cal_fill_q;
    zero_d        = zero_q;
    was_stopped_d = was_stopped_q;
    since_d       = since_q;
    last_recal_d  = last_recal_q;
    s1_win_d      = 1'b0;
    s1_zupd_d     = 1'b0;
    s1_recal_d    = 1'b0;
    if (guard_hit) begin
      if (g_last) begin
        s1_win_d     = 1'b1;
        guard_acc_d  = '0;
        guard_fill_d = '0;
      end else begin
        guard_acc_d  = g_sum;
        guard_fill_d = guard_fill_q + 1'b1;
      end
    end
    if (cal_hit) begin
      if (c_last) begin
        s1_zupd_d  = 1'b1;
        zero_d     = c_sum;
        cal_acc_d  = '0;
        cal_fill_d = '0;
      end else begin
        cal_acc_d  = c_sum;
        cal_fill_d = cal_fill_q + 1'b1;
      end
    end
    if (tick_hit) begin
      if (!cmd_i.door_stopped) begin
        was_stopped_d = 1'b0;
      end else begin
        was_stopped_d = 1'b1;
        since_d       = since_eff;
        if (recal_gap >= interval_q && since_gap >= idle_q) begin
          s1_recal_d   = 1'b1;
          last_recal_d = cmd_i.now;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_acc_q   <= '0;
      guard_fill_q  <= '0;
      cal_acc_q     <= '0;
      cal_fill_q    <= '0;
      zero_q        <= '0;
      was_stopped_q <= 1'b0;
      since_q       <= '0;
      last_recal_q  <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      guard_acc_q   <= guard_acc_d;
      guard_fill_q  <= guard_fill_d;
      cal_acc_q     <= cal_acc_d;
      cal_fill_q    <= cal_fill_d;
      zero_q        <= zero_d;
      was_stopped_q <= was_stopped_d;
      since_q       <= since_d;
      last_recal_q  <= last_recal_d;
      if (advance) begin
        s1_valid_q <= cmd_pop_o;
      end
    end
  end

  // Load the compare stage; the zero is captured so later calibrations do not leak in
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_win_q     <= s1_win_d;
      s1_zupd_q    <= s1_zupd_d;
      s1_recal_q   <= s1_recal_d;
      s1_acc_q     <= g_sum;
      s1_zero_q    <= zero_q;
      s1_slow_q    <= cmd_i.slow;
      s1_closing_q <= cmd_i.closing;
      s1_nc_q      <= cmd_i.near_closed;
      s1_no_q      <= cmd_i.near_open;
    end
  end

  // Compare the window against the limit, 80 percent in slow mode
  always_comb begin
    diff = (s1_acc_q >= s1_zero_q) ? s1_acc_q - s1_zero_q : s1_zero_q - s1_acc_q;
    if (s1_slow_q) begin
      lhs = CMP_W'(diff) + (CMP_W'(diff) << 2);
      rhs = CMP_W'(base4_q);
    end else begin
      lhs = CMP_W'(diff);
      rhs = CMP_W'(base_q);
    end
    over = lhs > rhs;
  end

  // Count over-limit windows and pick the trip action
  always_comb begin
    cnt   = (over_run_q != RUN_MAX) ? over_run_q + 1'b1 : RUN_MAX;
    trip  = s1_win_q && over && (cnt >= trip_q);
    if (over && !trip) begin
      run_next = cnt;
    end else begin
      run_next = '0;
    end
    res_d.window_done  = s1_win_q;
    res_d.tripped      = trip;
    res_d.zero_updated = s1_zupd_q;
    res_d.recal_due    = s1_recal_q;
    res_d.over_windows = s1_win_q ? run_next : over_run_q;
    if (!trip) begin
      res_d.trip_action = ACT_NONE;
    end else if (s1_closing_q) begin
      res_d.trip_action = s1_nc_q ? ACT_RESYNC_CLOSED : ACT_REVERSE;
    end else begin
      res_d.trip_action = s1_no_q ? ACT_RESYNC_OPEN : ACT_STOP_OPENING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_run_q <= '0;
    end else if (res_push && s1_win_q) begin
      over_run_q <= run_next;
    end
  end

  motg_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

`ifndef SYNTHESIS
  a_run_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !s1_win_q) |=> over_run_q == $past(over_run_q))
    else $error("over-limit count moved on a non-window item");

  a_trip_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_d.tripped) |=> over_run_q == '0)
    else $error("over-limit count not cleared after trip");

  a_action_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> ((res_d.trip_action != ACT_NONE) == res_d.tripped))
    else $error("trip action does not agree with trip flag");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    guard_fill_q < FILL_W'(GUARD_SAMPLES))
    else $error("guard fill count past window length");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> s1_valid_q)
    else $error("compare stage lost an item while stalled");
`endif

endmodule

// ===== design/motor_overcurrent_trip_guard_unit.sv =====
// Top level of the motor overcurrent trip guard.
// Depends on motg_pkg, motg_front and motg_back.
//
// Usage:
//   Input items enter through a queue-like port: an item is taken on a clock
//   edge with push high and full low. Each item is a guard sample, a
//   calibration sample or a millisecond tick, selected by its action field.
//   Every item yields exactly one result, presented on out_item_o while empty
//   is low and removed on an edge with pop high.
//   Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
//   taken on any edge with cfg_we_i high; write it only while the block is
//   idle.
//   A result becomes visible once its item has passed the command queue, the
//   accumulate step and the window compare stage into the result queue.
//   Throughput: one item per cycle while the result queue is not full.
//   A short command queue sits between the classifying front end and the
//   execution back end, and a two-entry result queue sits at the output; when
//   pop stays low the result queue fills, the back end holds its compare
//   stage, the command queue fills and full rises.
//   Reset clears all accumulators, counts, the zero and the time marks, and
//   loads the register defaults; there is no clearing pass.
module motor_overcurrent_trip_guard_unit #(
  parameter int unsigned GUARD_SAMPLES = 32,
  parameter int unsigned CAL_SAMPLES   = 200,
  parameter int unsigned ADC_BITS      = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [motg_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [motg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            push,
  input  motg_pkg::in_item_t              in_item_i,
  output logic                            full,
  input  logic                            pop,
  output logic                            empty,
  output motg_pkg::out_item_t             out_item_o
);
  import motg_pkg::*;

  localparam int unsigned SAMP_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam int unsigned CG     = $clog2(GUARD_SAMPLES);
  localparam int unsigned CC     = $clog2(CAL_SAMPLES);
  localparam int unsigned SC_W   = SAMP_W + ((CG > CC) ? CG : CC);

  cmd_t            cmd;
  logic [SC_W-1:0] scaled;
  logic            cmd_valid, cmd_pop;

  motg_front #(
    .GUARD_SAMPLES (GUARD_SAMPLES),
    .CAL_SAMPLES   (CAL_SAMPLES),
    .ADC_BITS      (ADC_BITS),
    .SC_W          (SC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .scaled_o    (scaled),
    .cmd_pop_i   (cmd_pop)
  );

  motg_back #(
    .GUARD_SAMPLES (GUARD_SAMPLES),
    .CAL_SAMPLES   (CAL_SAMPLES),
    .ADC_BITS      (ADC_BITS),
    .SC_W          (SC_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .scaled_i    (scaled),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for motor_overcurrent_trip_guard_unit.
// Uses motg_pkg for item structs and codes, and predicts each result with a local model.
// Random pacing on push and pop, and periodic long pop holds to fill the block.
module tb;
  import motg_pkg::*;

  localparam logic [1:0] ACTION_UNUSED = 2'd3;
  localparam int unsigned GUARD_N      = 32;
  localparam int unsigned CAL_N        = 200;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned HOLD_EVERY   = 300;
  localparam int unsigned SHOW_MAX     = 10;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx_i   = REG_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push        = 1'b0;
  in_item_t              in_item_i   = '0;
  logic                  full;
  logic                  pop         = 1'b0;
  logic                  empty;
  out_item_t             out_item_o;

  motor_overcurrent_trip_guard_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

  // Register copies
  logic [LIMIT_W-1:0] lim_cnt;
  logic [TRIP_W-1:0]  trips_needed;
  logic [TIME_W-1:0]  recal_gap;
  logic [TIME_W-1:0]  idle_need;

  // Guard state copy
  logic [16:0]        acc_guard;
  logic [5:0]         fill_guard;
  logic [19:0]        acc_cal;
  logic [7:0]         fill_cal;
  logic [19:0]        zero_sum;
  logic [TRIP_W-1:0]  over_cnt;
  logic               door_was_stopped;
  logic [TIME_W-1:0]  stop_mark;
  logic [TIME_W-1:0]  recal_mark;

  in_item_t  item_q[$];
  out_item_t report_q[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned n_err        = 0;
  int unsigned n_reports    = 0;
  int unsigned hold_left    = 0;

  // Stimulus generator state
  logic [TIME_W-1:0] gen_now     = '0;
  logic              gen_stopped = 1'b0;
  int                win_left    = 0;
  int                win_mean    = 0;
  int                win_spread  = 0;
  bit                win_noise   = 1'b0;
  bit                win_over    = 1'b1;

  always #5 clk_i = ~clk_i;

  function automatic void reset_guard();
    lim_cnt          = LIMIT_RST;
    trips_needed     = TRIP_RST;
    recal_gap        = INTERVAL_RST;
    idle_need        = IDLE_RST;
    acc_guard        = '0;
    fill_guard       = '0;
    acc_cal          = '0;
    fill_cal         = '0;
    zero_sum         = '0;
    over_cnt         = '0;
    door_was_stopped = 1'b0;
    stop_mark        = '0;
    recal_mark       = '0;
  endfunction

  // Compare the window deviation from zero with the limit, scaled to integers
  function automatic bit window_exceeds(input logic slow);
    longint unsigned lhs, rhs, diff, bound;
    lhs   = CAL_N * acc_guard;
    rhs   = GUARD_N * zero_sum;
    diff  = (lhs > rhs) ? lhs - rhs : rhs - lhs;
    bound = GUARD_N * CAL_N * lim_cnt;
    if (slow) return (5 * diff) > (4 * bound);
    return diff > bound;
  endfunction

  // Advance the guard state by one item and return its report
  function automatic out_item_t compute_report(input in_item_t it);
    out_item_t  r;
    logic [8:0] cnt;
    r = '0;
    case (it.action)
      ACTION_GUARD: begin
        acc_guard  = acc_guard + it.adc_sample;
        fill_guard = fill_guard + 1'b1;
        if (fill_guard >= GUARD_N) begin
          r.window_done = 1'b1;
          if (window_exceeds(it.slow_mode)) begin
            cnt = (over_cnt == RUN_MAX) ? {1'b0, RUN_MAX} : over_cnt + 9'd1;
            if (cnt >= trips_needed) begin
              r.tripped = 1'b1;
              if (it.closing) r.trip_action = it.near_closed ? ACT_RESYNC_CLOSED : ACT_REVERSE;
              else r.trip_action = it.near_open ? ACT_RESYNC_OPEN : ACT_STOP_OPENING;
              cnt = '0;
            end
            over_cnt = cnt[TRIP_W-1:0];
          end else begin
            over_cnt = '0;
          end
          acc_guard  = '0;
          fill_guard = '0;
        end
      end
      ACTION_CAL: begin
        acc_cal  = acc_cal + it.adc_sample;
        fill_cal = fill_cal + 1'b1;
        if (fill_cal >= CAL_N) begin
          zero_sum       = acc_cal;
          r.zero_updated = 1'b1;
          acc_cal        = '0;
          fill_cal       = '0;
        end
      end
      ACTION_TICK: begin
        if (!it.door_stopped) begin
          door_was_stopped = 1'b0;
        end else begin
          if (!door_was_stopped) begin
            door_was_stopped = 1'b1;
            stop_mark        = it.now_ms;
          end
          if ((it.now_ms - recal_mark) >= recal_gap && (it.now_ms - stop_mark) >= idle_need) begin
            r.recal_due = 1'b1;
            recal_mark  = it.now_ms;
          end
        end
      end
      default: ;
    endcase
    r.over_windows = over_cnt;
    return r;
  endfunction

  function automatic logic [ADC_W-1:0] clamp_adc(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return v[ADC_W-1:0];
  endfunction

  task automatic queue_item(input logic [1:0] act, input logic [ADC_W-1:0] smp,
                            input logic stopped, input logic [TIME_W-1:0] now);
    in_item_t it;
    it.action       = act;
    it.adc_sample   = smp;
    it.slow_mode    = $urandom_range(1);
    it.closing      = $urandom_range(1);
    it.near_closed  = $urandom_range(1);
    it.near_open    = $urandom_range(1);
    it.door_stopped = stopped;
    it.now_ms       = now;
    item_q.push_back(it);
  endtask

  // Mix guard windows aimed around the limit, calibration runs, ticks and junk
  task automatic gen_random(input int count, input int cal_lvl, input int unsigned tick_step);
    int base;
    int offs;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        if (win_left == 0) begin
          win_left = GUARD_N;
          if ($urandom_range(99) < 15) win_over = !win_over;
          win_noise  = ($urandom_range(11) == 0);
          win_spread = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(3, 1));
          base = zero_sum / CAL_N;
          if (win_over) begin
            offs = int'(lim_cnt) + 1 + (($urandom_range(3) == 0) ? int'($urandom_range(400))
                                                                 : int'($urandom_range(2)));
          end else if ($urandom_range(1) == 0) begin
            offs = int'(lim_cnt) - int'($urandom_range(2));
          end else begin
            offs = int'($urandom_range(lim_cnt));
          end
          if (offs < 0) offs = 0;
          win_mean = ($urandom_range(1) == 0) ? base + offs : base - offs;
        end
        win_left--;
        if (win_noise) begin
          queue_item(ACTION_GUARD, $urandom_range(4095), $urandom_range(1), $urandom());
        end else begin
          queue_item(ACTION_GUARD,
                     clamp_adc(win_mean + int'($urandom_range(2 * win_spread)) - win_spread),
                     $urandom_range(1), $urandom());
        end
      end else if (pick < 88) begin
        queue_item(ACTION_CAL, ($urandom_range(6) == 0) ? $urandom_range(4095) : cal_lvl,
                   $urandom_range(1), $urandom());
      end else if (pick < 97) begin
        if ($urandom_range(99) < 15) gen_stopped = !gen_stopped;
        if ($urandom_range(19) == 0) gen_now = $urandom();
        else gen_now = gen_now + $urandom_range(tick_step);
        queue_item(ACTION_TICK, $urandom_range(4095), gen_stopped, gen_now);
      end else begin
        queue_item(ACTION_UNUSED, $urandom_range(4095), $urandom_range(1), $urandom());
      end
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_LIMIT:    lim_cnt      = val[LIMIT_W-1:0];
      REG_TRIP:     trips_needed = val[TRIP_W-1:0];
      REG_INTERVAL: recal_gap    = val;
      REG_IDLE:     idle_need    = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] limit, input logic [CFG_DATA_W-1:0] trip,
                              input logic [CFG_DATA_W-1:0] interval,
                              input logic [CFG_DATA_W-1:0] idle);
    write_reg(REG_LIMIT, limit);
    write_reg(REG_TRIP, trip);
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_IDLE, idle);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every item is in and every report is out, then let the pipe settle
  task automatic drain();
    @(posedge clk_i);
    while (item_q.size() != 0 || push || report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer queued items; hold the current one while the block is full
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) report_q.push_back(compute_report(in_item_i));
      if (!push || !full) begin
        if (item_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          push      <= 1'b1;
          in_item_i <= item_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Check each popped report; pace pop and insert long holds now and then
  always @(posedge clk_i) begin
    out_item_t want;
    bit        start_hold;
    start_hold = 1'b0;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (report_q.size() == 0) begin
          n_err++;
          if (n_err <= SHOW_MAX) $display("unexpected report: %p", out_item_o);
        end else begin
          want = report_q.pop_front();
          if (out_item_o.window_done !== want.window_done ||
              out_item_o.tripped !== want.tripped ||
              out_item_o.trip_action !== want.trip_action ||
              out_item_o.over_windows !== want.over_windows ||
              out_item_o.zero_updated !== want.zero_updated ||
              out_item_o.recal_due !== want.recal_due) begin
            n_err++;
            if (n_err <= SHOW_MAX) begin
              $display("report mismatch: expected done=%0d trip=%0d act=%0d over=%0d zero=%0d recal=%0d",
                       want.window_done, want.tripped, want.trip_action, want.over_windows,
                       want.zero_updated, want.recal_due);
              $display("                 actual   done=%0d trip=%0d act=%0d over=%0d zero=%0d recal=%0d",
                       out_item_o.window_done, out_item_o.tripped, out_item_o.trip_action,
                       out_item_o.over_windows, out_item_o.zero_updated, out_item_o.recal_due);
            end
          end
        end
        n_reports++;
        start_hold = (n_reports % HOLD_EVERY == 0);
      end
      if (start_hold) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      pop <= !start_hold && hold_left == 0 && $urandom_range(99) >= recv_gap_pct;
    end
  end

  // Run limit
  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    reset_guard();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_gap_pct = 18;
    recv_gap_pct = 63;

    // Directed: unknown action, tick edge cases with wrapping time, sample extremes
    queue_item(ACTION_UNUSED, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
    queue_item(ACTION_UNUSED, 12'h000, 1'b0, 32'h0000_0000);
    queue_item(ACTION_TICK, 12'h000, 1'b0, 32'd5);
    queue_item(ACTION_TICK, 12'hFFF, 1'b1, 32'd0);
    queue_item(ACTION_TICK, 12'h000, 1'b1, 32'hFFFF_FFFF);
    queue_item(ACTION_TICK, 12'h000, 1'b1, 32'h8000_0000);
    queue_item(ACTION_TICK, 12'h000, 1'b0, 32'd1);
    queue_item(ACTION_TICK, 12'h000, 1'b1, 32'h7FFF_FFFF);
    queue_item(ACTION_GUARD, 12'h000, 1'b0, 32'h5555_5555);
    queue_item(ACTION_GUARD, 12'hFFF, 1'b1, 32'hAAAA_AAAA);
    queue_item(ACTION_CAL, 12'h000, 1'b0, 32'h0);
    queue_item(ACTION_CAL, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
    gen_now     = 32'h8000_0000;
    gen_stopped = 1'b1;
    gen_random(210, 1500, 20000);
    drain();

    // Zero limit, trip on every over window, recal whenever stopped
    program_regs(0, 1, 0, 0);
    gen_random(230, 1500, 50);
    drain();

    // Largest settings, swapped pacing
    send_gap_pct = 63;
    recv_gap_pct = 18;
    program_regs(4095, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    gen_random(220, 3000, 32'h4000_0000);
    drain();

    program_regs(40, 3, 300, 100);
    gen_random(240, 800, 100);
    drain();

    // Trip count of zero, no idling
    send_gap_pct = 0;
    recv_gap_pct = 0;
    program_regs(25, 0, 1000, 0);
    gen_random(240, 2000, 400);
    drain();

    program_regs($urandom_range(200), $urandom_range(6, 1), $urandom_range(2000),
                 $urandom_range(2000));
    gen_random(250, $urandom_range(4095), 300);
    drain();

    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
